### rtl/core/mpc_pkg.sv
// Shared types, codes and constants for the masked pixel compositor.
`default_nettype none
package mpc_pkg;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] OP_PIXEL    = 3'd0;
  localparam logic [2:0] OP_LOAD_FG  = 3'd1;
  localparam logic [2:0] OP_LOAD_TGT = 3'd2;
  localparam logic [2:0] OP_MERGE    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [2:0] MODE_MONO    = 3'd0;
  localparam logic [2:0] MODE_DIRECT  = 3'd1;
  localparam logic [2:0] MODE_PAL_RGB = 3'd2;
  localparam logic [2:0] MODE_PAL_IDX = 3'd3;
  localparam logic [2:0] MODE_APPLY   = 3'd4;

  localparam logic [1:0] REG_COMBINE_MODE   = 2'd0;
  localparam logic [1:0] REG_USE_MASK       = 2'd1;
  localparam logic [1:0] REG_FILL_WHITE     = 2'd2;
  localparam logic [1:0] REG_INDEXED_TARGET = 2'd3;

  localparam logic [DATA_W-1:0] BLACK_PIX = 32'hff00_0000;
  localparam logic [DATA_W-1:0] WHITE_PIX = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] ZERO_PIX  = 32'h0000_0000;

  typedef logic [DATA_W-1:0] pixel_t;

  function automatic logic is_white(input pixel_t v, input logic indexed);
    if (indexed) begin
      return v[7:0] == 8'hff;
    end
    return v[23:0] == 24'hff_ffff;
  endfunction
endpackage
`default_nettype wire

### rtl/core/mpc_pal_ram.sv
// Palette memory with one write port and one registered read port.
`default_nettype none
module mpc_pal_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire mpc_pkg::pixel_t      wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output mpc_pkg::pixel_t           rdata
);
  import mpc_pkg::*;

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/masked_pixel_compositor_unit.sv
// Top level of the masked pixel compositor: control sequencer and palette memories.
// Flow: a plain pixel, palette load or clear passes through S_EXEC and S_FIN; a palette pixel
// adds S_FGW, and an indexed lookup adds a scan of the target memory (S_TSTART, then S_TRD and
// S_TCMP for each entry, then S_SDONE). A merge runs S_MRD, S_MW and a target scan for each
// foreground entry. One transaction is in flight at a time: a new one is taken only in S_IDLE.
// Reset (rst, synchronous) empties both palettes and loads defaults.
`default_nettype none
module masked_pixel_compositor_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // base_pixel[31:0], fg_value[63:32], mask_bit[64], entry_color[96:65], zero pad
  input  wire [103:0] s_tdata,
  // operation[2:0]
  input  wire [2:0]   s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // out_pixel[31:0], written[32], target_entries[41:33], zero pad
  output logic [47:0] m_tdata,
  input  wire         cfg_we,
  input  wire [1:0]   cfg_index,
  input  wire [2:0]   cfg_data
);
  import mpc_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(PALETTE_ENTRIES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_FGW    = 4'd2;
  localparam logic [3:0] S_TSTART = 4'd3;
  localparam logic [3:0] S_TRD    = 4'd4;
  localparam logic [3:0] S_TCMP   = 4'd5;
  localparam logic [3:0] S_SDONE  = 4'd6;
  localparam logic [3:0] S_MRD    = 4'd7;
  localparam logic [3:0] S_MW     = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state;
  logic [2:0] combine_mode;
  logic use_mask, fill_white, indexed_target;

  logic [2:0] op_q;
  pixel_t base_q, fg_q, entry_q, color_q, res_pix;
  logic mask_q, res_wr, fg_hit, found;
  logic [CNT_W-1:0] fg_cnt, t_cnt, scan_i, m_i;
  logic [IDX_W-1:0] found_idx;

  pixel_t exec_pix;
  logic exec_wr, exec_pal;

  logic fg_we, t_we;
  logic [IDX_W-1:0] fg_waddr, fg_raddr, t_waddr, t_raddr;
  pixel_t fg_wdata, t_wdata, fg_rdata, t_rdata, fg_color;

  mpc_pal_ram #(.DEPTH(PALETTE_ENTRIES)) u_fg_ram (
    .clk(clk), .we(fg_we), .waddr(fg_waddr), .wdata(fg_wdata),
    .raddr(fg_raddr), .rdata(fg_rdata)
  );

  mpc_pal_ram #(.DEPTH(PALETTE_ENTRIES)) u_tgt_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign fg_color = fg_hit ? fg_rdata : ZERO_PIX;

  always_comb begin
    fg_we    = 1'b0;
    fg_waddr = fg_cnt[IDX_W-1:0];
    fg_wdata = entry_q;
    fg_raddr = fg_q[IDX_W-1:0];
    t_we     = 1'b0;
    t_waddr  = t_cnt[IDX_W-1:0];
    t_wdata  = entry_q;
    t_raddr  = scan_i[IDX_W-1:0];
    case (state)
      S_EXEC: begin
        fg_we = (op_q == OP_LOAD_FG) && (fg_cnt < FULL);
        t_we  = (op_q == OP_LOAD_TGT) && (t_cnt < FULL);
      end
      S_MRD: fg_raddr = m_i[IDX_W-1:0];
      S_SDONE: begin
        t_we    = (op_q == OP_MERGE) && !found;
        t_wdata = color_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    exec_pix = base_q;
    exec_wr  = 1'b0;
    exec_pal = 1'b0;
    if (op_q == OP_PIXEL) begin
      case (combine_mode) inside
        MODE_MONO: begin
          if (use_mask) begin
            if (mask_q) begin
              exec_pix = fg_q[0] ? BLACK_PIX : WHITE_PIX;
              exec_wr  = 1'b1;
            end
          end else if (fg_q[0]) begin
            exec_pix = BLACK_PIX;
            exec_wr  = 1'b1;
          end
        end
        MODE_DIRECT: begin
          if (use_mask ? mask_q : !is_white(fg_q, indexed_target)) begin
            exec_pix = fg_q;
            exec_wr  = 1'b1;
          end
        end
        MODE_PAL_RGB, MODE_PAL_IDX: exec_pal = 1'b1;
        MODE_APPLY: begin
          if (!mask_q) begin
            exec_pix = fill_white ? WHITE_PIX : ZERO_PIX;
            exec_wr  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      combine_mode   <= MODE_MONO;
      use_mask       <= 1'b0;
      fill_white     <= 1'b1;
      indexed_target <= 1'b0;
      fg_cnt         <= '0;
      t_cnt          <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COMBINE_MODE:   combine_mode   <= cfg_data;
          REG_USE_MASK:       use_mask       <= cfg_data[0];
          REG_FILL_WHITE:     fill_white     <= cfg_data[0];
          REG_INDEXED_TARGET: indexed_target <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q    <= s_tuser;
            base_q  <= s_tdata[31:0];
            fg_q    <= s_tdata[63:32];
            mask_q  <= s_tdata[64];
            entry_q <= s_tdata[96:65];
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_pix <= exec_pix;
          res_wr  <= exec_wr;
          if (exec_pal) begin
            fg_hit <= {1'b0, fg_q[7:0]} < 9'(fg_cnt);
            state  <= S_FGW;
          end else if (op_q == OP_MERGE) begin
            m_i   <= '0;
            state <= S_MRD;
          end else begin
            state <= S_FIN;
          end
          case (op_q)
            OP_LOAD_FG: begin
              if (fg_cnt < FULL) begin
                fg_cnt <= fg_cnt + 1'b1;
              end
            end
            OP_LOAD_TGT: begin
              if (t_cnt < FULL) begin
                t_cnt <= t_cnt + 1'b1;
              end
            end
            OP_CLEAR: begin
              fg_cnt <= '0;
              t_cnt  <= '0;
            end
            default: ;
          endcase
        end
        S_FGW: begin
          if (use_mask ? mask_q : !is_white(fg_color, indexed_target)) begin
            res_wr <= 1'b1;
            if (combine_mode == MODE_PAL_RGB) begin
              res_pix <= fg_color;
              state   <= S_FIN;
            end else begin
              color_q <= fg_color;
              state   <= S_TSTART;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_TSTART: begin
          found     <= 1'b0;
          found_idx <= '0;
          scan_i    <= '0;
          state     <= (t_cnt == '0) ? S_SDONE : S_TRD;
        end
        S_TRD: state <= S_TCMP;
        S_TCMP: begin
          if (t_rdata == color_q) begin
            found     <= 1'b1;
            found_idx <= scan_i[IDX_W-1:0];
          end
          if (CNT_W'(scan_i + 1'b1) == t_cnt) begin
            state <= S_SDONE;
          end else begin
            scan_i <= scan_i + 1'b1;
            state  <= S_TRD;
          end
        end
        S_SDONE: begin
          if (op_q == OP_MERGE) begin
            if (!found) begin
              t_cnt <= t_cnt + 1'b1;
            end
            m_i   <= m_i + 1'b1;
            state <= S_MRD;
          end else begin
            res_pix <= DATA_W'(found_idx);
            state   <= S_FIN;
          end
        end
        S_MRD: begin
          state <= ((m_i == fg_cnt) || (t_cnt == FULL)) ? S_FIN : S_MW;
        end
        S_MW: begin
          color_q <= fg_rdata;
          state   <= S_TSTART;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata[31:0]  <= indexed_target ? {24'd0, res_pix[7:0]} : res_pix;
            m_tdata[32]    <= res_wr;
            m_tdata[41:33] <= 9'(t_cnt);
            m_tdata[47:42] <= '0;
            m_tvalid       <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
